### rtl/core/hdf_pkg.sv
`timescale 1ns / 1ps
// Package for the HTTP response deframer: shared constants, types and
// character lookups. Depends on nothing.
package hdf_pkg;

   localparam int LINE_BUFFER_DEF = 128;
   localparam int SIZE_DIGITS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_CLOSE   = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;
   localparam logic [1:0] CMD_START   = 2'd3;

   localparam logic [0:0] REG_HEAD_REQUEST = 1'b0;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   localparam logic [15:0] STATUS_NO_CONTENT   = 16'd204;
   localparam logic [15:0] STATUS_NOT_MODIFIED = 16'd304;

   localparam int CL_NAME_LEN = 14;
   localparam int TE_NAME_LEN = 17;
   localparam logic [2:0] HTTP_PREFIX_LEN = 3'd5;
   localparam logic [2:0] PREFIX_MISMATCH = 3'd7;
   localparam logic [2:0] CHUNKED_LEN     = 3'd7;

   typedef struct packed {
      logic        has_data;
      logic [7:0]  data;
      logic        has_cmp;
      logic        success;
      logic [15:0] status;
   } res_entry_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [7:0] l;
      l = to_lower(c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if (l >= 8'h61 && l <= 8'h66) return {1'b1, 4'(l - 8'h57)};
      return 5'd0;
   endfunction

   function automatic logic [7:0] http_char(input logic [2:0] i);
      unique case (i)
         3'd0: return 8'h48;
         3'd1: return 8'h54;
         3'd2: return 8'h54;
         3'd3: return 8'h50;
         3'd4: return 8'h2F;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ck_char(input logic [2:0] i);
      unique case (i)
         3'd0: return 8'h63;
         3'd1: return 8'h68;
         3'd2: return 8'h75;
         3'd3: return 8'h6E;
         3'd4: return 8'h6B;
         3'd5: return 8'h65;
         3'd6: return 8'h64;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      unique case (i)
         5'd0: return 8'h63;
         5'd1: return 8'h6F;
         5'd2: return 8'h6E;
         5'd3: return 8'h74;
         5'd4: return 8'h65;
         5'd5: return 8'h6E;
         5'd6: return 8'h74;
         5'd7: return 8'h2D;
         5'd8: return 8'h6C;
         5'd9: return 8'h65;
         5'd10: return 8'h6E;
         5'd11: return 8'h67;
         5'd12: return 8'h74;
         5'd13: return 8'h68;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] i);
      unique case (i)
         5'd0: return 8'h74;
         5'd1: return 8'h72;
         5'd2: return 8'h61;
         5'd3: return 8'h6E;
         5'd4: return 8'h73;
         5'd5: return 8'h66;
         5'd6: return 8'h65;
         5'd7: return 8'h72;
         5'd8: return 8'h2D;
         5'd9: return 8'h65;
         5'd10: return 8'h6E;
         5'd11: return 8'h63;
         5'd12: return 8'h6F;
         5'd13: return 8'h64;
         5'd14: return 8'h69;
         5'd15: return 8'h6E;
         5'd16: return 8'h67;
         default: return 8'h00;
      endcase
   endfunction

endpackage

### rtl/core/hdf_front.sv
`timescale 1ns / 1ps
// Front part of the deframer: parses headers and body framing one word per
// cycle while accept is high and emits a result entry. Depends on hdf_pkg.
module hdf_front #(
   parameter int LINE_BUFFER = hdf_pkg::LINE_BUFFER_DEF,
   parameter int SIZE_DIGITS = hdf_pkg::SIZE_DIGITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             command,
   input  logic [7:0]             data_byte,
   input  logic                   head_request,
   output logic                   push,
   output hdf_pkg::res_entry_type entry
);

   localparam int LC_W = $clog2(LINE_BUFFER);
   localparam int SD_W = $clog2(SIZE_DIGITS + 1);

   typedef enum logic [2:0] {
      ST_HEAD = 3'b001,
      ST_BODY = 3'b010,
      ST_DONE = 3'b100
   } stage_type;

   typedef enum logic [5:0] {
      CP_SIZE    = 6'b000001,
      CP_SIZE_LF = 6'b000010,
      CP_DATA    = 6'b000100,
      CP_DATA_CR = 6'b001000,
      CP_DATA_LF = 6'b010000,
      CP_TRAILER = 6'b100000
   } chunk_phase_type;

   typedef struct packed {
      logic colon;
      logic space;
      logic clbad;
      logic tebad;
      logic neg;
      logic iscl;
      logic iste;
      logic stat;
   } line_flags_type;

   stage_type       stage_ff, stage_in;
   chunk_phase_type phase_ff, phase_in;
   line_flags_type  flags_ff, flags_in;
   logic [LC_W-1:0] lc_ff, lc_in;
   logic            awaiting_ff, awaiting_in;
   logic [2:0]      prefix_ff, prefix_in;
   logic [2:0]      wp_ff, wp_in;
   logic [15:0]     status_ff, status_in;
   logic [31:0]     len_ff, len_in;
   logic            known_ff, known_in;
   logic            chunked_ff, chunked_in;
   logic [31:0]     left_ff, left_in;
   logic [SD_W-1:0] sd_ff, sd_in;

   logic [7:0]  b;
   logic [7:0]  lb;
   logic        dig;
   logic [3:0]  dval;
   logic [15:0] status10;
   logic [35:0] len36;
   logic [31:0] len_sat;
   logic [4:0]  hx;
   logic [4:0]  pidx;

   assign b        = data_byte;
   assign lb       = hdf_pkg::to_lower(data_byte);
   assign dig      = (b >= 8'h30) && (b <= 8'h39);
   assign dval     = b[3:0];
   assign status10 = 16'((status_ff << 3) + (status_ff << 1) + 16'(dval));
   assign len36    = ({4'd0, len_ff} << 3) + ({4'd0, len_ff} << 1) + 36'(dval);
   assign len_sat  = (len36[35:32] != 4'd0) ? 32'hFFFF_FFFF : len36[31:0];
   assign hx       = hdf_pkg::hex_val(b);
   assign pidx     = lc_ff[4:0];

   always_comb begin
      stage_in    = stage_ff;
      phase_in    = phase_ff;
      flags_in    = flags_ff;
      lc_in       = lc_ff;
      awaiting_in = awaiting_ff;
      prefix_in   = prefix_ff;
      wp_in       = wp_ff;
      status_in   = status_ff;
      len_in      = len_ff;
      known_in    = known_ff;
      chunked_in  = chunked_ff;
      left_in     = left_ff;
      sd_in       = sd_ff;
      entry       = '0;
      if (accept) begin
         if (command == hdf_pkg::CMD_START) begin
            stage_in    = ST_HEAD;
            phase_in    = CP_SIZE;
            flags_in    = '0;
            lc_in       = '0;
            awaiting_in = 1'b0;
            prefix_in   = '0;
            wp_in       = '0;
            status_in   = '0;
            len_in      = '0;
            known_in    = 1'b0;
            chunked_in  = 1'b0;
            left_in     = '0;
            sd_in       = '0;
         end else begin
            unique case (stage_ff)
               ST_HEAD: begin
                  if (command != hdf_pkg::CMD_BYTE) begin
                     entry.has_cmp = 1'b1;
                     stage_in = ST_DONE;
                  end else if (awaiting_ff) begin
                     awaiting_in = 1'b0;
                     if (b != hdf_pkg::CH_LF) begin
                        entry.has_cmp = 1'b1;
                        stage_in = ST_DONE;
                     end else if (lc_ff == '0) begin
                        flags_in = '0;
                        wp_in    = '0;
                        sd_in    = '0;
                        phase_in = CP_SIZE;
                        left_in  = '0;
                        if (head_request || status_ff == hdf_pkg::STATUS_NO_CONTENT
                            || status_ff == hdf_pkg::STATUS_NOT_MODIFIED
                            || (!chunked_ff && known_ff && len_ff == '0)) begin
                           entry.has_cmp = 1'b1;
                           entry.success = 1'b1;
                           entry.status  = status_ff;
                           stage_in = ST_DONE;
                        end else begin
                           stage_in = ST_BODY;
                        end
                     end else begin
                        if (prefix_ff == hdf_pkg::HTTP_PREFIX_LEN) begin
                           if (flags_ff.stat && flags_ff.neg) status_in = 16'd0 - status_ff;
                        end else if (flags_ff.iscl) begin
                           if (flags_ff.neg && len_ff != '0) begin
                              known_in = 1'b0;
                              len_in   = '0;
                           end else begin
                              known_in = 1'b1;
                           end
                        end
                        lc_in     = '0;
                        prefix_in = '0;
                        flags_in  = '0;
                        wp_in     = '0;
                     end
                  end else if (b == hdf_pkg::CH_CR) begin
                     awaiting_in = 1'b1;
                  end else if (lc_ff < LC_W'(LINE_BUFFER - 1)) begin
                     lc_in = lc_ff + 1'b1;
                     if (prefix_ff < hdf_pkg::HTTP_PREFIX_LEN) begin
                        prefix_in = (b == hdf_pkg::http_char(prefix_ff)) ?
                                    prefix_ff + 3'd1 : hdf_pkg::PREFIX_MISMATCH;
                     end
                     if (flags_ff.stat || flags_ff.iscl) begin
                        if (wp_ff == 3'd0) begin
                           if (!hdf_pkg::is_ws(b)) begin
                              wp_in = 3'd1;
                              if (b == hdf_pkg::CH_MINUS) begin
                                 flags_in.neg = 1'b1;
                              end else if (b == hdf_pkg::CH_PLUS) begin
                                 wp_in = 3'd1;
                              end else if (!dig) begin
                                 wp_in = 3'd2;
                              end else if (flags_ff.stat) begin
                                 status_in = status10;
                              end else begin
                                 len_in = len_sat;
                              end
                           end
                        end else if (wp_ff != 3'd1 || !dig) begin
                           wp_in = 3'd2;
                        end else if (flags_ff.stat) begin
                           status_in = status10;
                        end else begin
                           len_in = len_sat;
                        end
                     end else if (flags_ff.iste && wp_ff < hdf_pkg::CHUNKED_LEN) begin
                        if (lb == hdf_pkg::ck_char(wp_ff)) begin
                           wp_in = wp_ff + 3'd1;
                           if (wp_ff + 3'd1 == hdf_pkg::CHUNKED_LEN) chunked_in = 1'b1;
                        end else begin
                           wp_in = (lb == hdf_pkg::ck_char(3'd0)) ? 3'd1 : 3'd0;
                        end
                     end
                     if (!flags_ff.space && b == hdf_pkg::CH_SPACE) begin
                        flags_in.space = 1'b1;
                        if (prefix_in == hdf_pkg::HTTP_PREFIX_LEN) begin
                           flags_in.stat = 1'b1;
                           flags_in.neg  = 1'b0;
                           status_in     = '0;
                           wp_in         = '0;
                        end
                     end
                     if (!flags_ff.colon) begin
                        if (b == hdf_pkg::CH_COLON) begin
                           flags_in.colon = 1'b1;
                           if (prefix_in != hdf_pkg::HTTP_PREFIX_LEN) begin
                              if (!flags_ff.clbad && lc_ff == LC_W'(hdf_pkg::CL_NAME_LEN)) begin
                                 flags_in.iscl = 1'b1;
                                 flags_in.neg  = 1'b0;
                                 len_in        = '0;
                                 wp_in         = '0;
                              end else if (!flags_ff.tebad
                                           && lc_ff == LC_W'(hdf_pkg::TE_NAME_LEN)) begin
                                 flags_in.iste = 1'b1;
                                 wp_in         = '0;
                              end
                           end
                        end else begin
                           if (lc_ff >= LC_W'(hdf_pkg::CL_NAME_LEN)
                               || lb != hdf_pkg::cl_char(pidx)) flags_in.clbad = 1'b1;
                           if (lc_ff >= LC_W'(hdf_pkg::TE_NAME_LEN)
                               || lb != hdf_pkg::te_char(pidx)) flags_in.tebad = 1'b1;
                        end
                     end
                  end
               end
               ST_BODY: begin
                  if (command == hdf_pkg::CMD_TIMEOUT) begin
                     entry.has_cmp = 1'b1;
                     entry.status  = status_ff;
                     stage_in = ST_DONE;
                  end else if (command == hdf_pkg::CMD_CLOSE) begin
                     entry.has_cmp = 1'b1;
                     entry.success = !(chunked_ff || known_ff);
                     entry.status  = status_ff;
                     stage_in = ST_DONE;
                  end else if (chunked_ff) begin
                     unique case (phase_ff)
                        CP_SIZE: begin
                           if (b == hdf_pkg::CH_CR) begin
                              phase_in = CP_SIZE_LF;
                           end else if (sd_ff < SD_W'(SIZE_DIGITS)) begin
                              sd_in = sd_ff + 1'b1;
                              case (wp_ff) inside
                                 3'd0, 3'd1: begin
                                    if (wp_ff == 3'd0 && hdf_pkg::is_ws(b)) begin
                                       wp_in = wp_ff;
                                    end else if (wp_ff == 3'd0 && (b == hdf_pkg::CH_MINUS
                                                 || b == hdf_pkg::CH_PLUS)) begin
                                       if (b == hdf_pkg::CH_MINUS) flags_in.neg = 1'b1;
                                       wp_in = 3'd1;
                                    end else if (!hx[4]) begin
                                       wp_in = 3'd3;
                                    end else if (hx[3:0] == 4'd0) begin
                                       left_in = '0;
                                       wp_in   = 3'd4;
                                    end else begin
                                       left_in = {28'd0, hx[3:0]};
                                       wp_in   = 3'd2;
                                    end
                                 end
                                 3'd2, 3'd4: begin
                                    if (wp_ff == 3'd4 && (b == 8'h78 || b == 8'h58)) begin
                                       wp_in = 3'd2;
                                    end else if (!hx[4]) begin
                                       wp_in = 3'd3;
                                    end else begin
                                       left_in = {left_ff[27:0], hx[3:0]};
                                       wp_in   = 3'd2;
                                    end
                                 end
                                 default: wp_in = wp_ff;
                              endcase
                           end
                        end
                        CP_SIZE_LF: begin
                           if (b == hdf_pkg::CH_LF) begin
                              left_in  = flags_ff.neg ? 32'd0 - left_ff : left_ff;
                              sd_in    = '0;
                              wp_in    = '0;
                              flags_in = '0;
                              phase_in = (left_in == '0) ? CP_TRAILER : CP_DATA;
                           end
                        end
                        CP_DATA: begin
                           entry.has_data = 1'b1;
                           entry.data     = b;
                           if (left_ff != '0) left_in = left_ff - 32'd1;
                           if (left_in == '0) phase_in = CP_DATA_CR;
                        end
                        CP_DATA_CR: begin
                           if (b == hdf_pkg::CH_CR) phase_in = CP_DATA_LF;
                        end
                        CP_DATA_LF: begin
                           if (b == hdf_pkg::CH_LF) phase_in = CP_SIZE;
                        end
                        CP_TRAILER: begin
                           if (b == hdf_pkg::CH_LF) begin
                              entry.has_cmp = 1'b1;
                              entry.success = 1'b1;
                              entry.status  = status_ff;
                              stage_in = ST_DONE;
                           end
                        end
                        default: phase_in = phase_ff;
                     endcase
                  end else begin
                     entry.has_data = 1'b1;
                     entry.data     = b;
                     if (known_ff) begin
                        if (len_ff != '0) len_in = len_ff - 32'd1;
                        if (len_in == '0) begin
                           entry.has_cmp = 1'b1;
                           entry.success = 1'b1;
                           entry.status  = status_ff;
                           stage_in = ST_DONE;
                        end
                     end
                  end
               end
               ST_DONE: stage_in = stage_ff;
               default: stage_in = stage_ff;
            endcase
         end
      end
   end

   assign push = entry.has_data || entry.has_cmp;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= ST_HEAD;
         phase_ff    <= CP_SIZE;
         flags_ff    <= '0;
         lc_ff       <= '0;
         awaiting_ff <= 1'b0;
         prefix_ff   <= '0;
         wp_ff       <= '0;
         status_ff   <= '0;
         len_ff      <= '0;
         known_ff    <= 1'b0;
         chunked_ff  <= 1'b0;
         left_ff     <= '0;
         sd_ff       <= '0;
      end else begin
         stage_ff    <= stage_in;
         phase_ff    <= phase_in;
         flags_ff    <= flags_in;
         lc_ff       <= lc_in;
         awaiting_ff <= awaiting_in;
         prefix_ff   <= prefix_in;
         wp_ff       <= wp_in;
         status_ff   <= status_in;
         len_ff      <= len_in;
         known_ff    <= known_in;
         chunked_ff  <= chunked_in;
         left_ff     <= left_in;
         sd_ff       <= sd_in;
      end
   end

   a_done_no_result: assert property (@(posedge clock) disable iff (reset)
      (stage_ff == ST_DONE && command != hdf_pkg::CMD_START) |-> !push)
      else $error("result produced after completion");
   a_cmp_ends: assert property (@(posedge clock) disable iff (reset)
      (accept && entry.has_cmp) |=> stage_ff == ST_DONE)
      else $error("completion did not end the response");
   a_prefix_range: assert property (@(posedge clock) disable iff (reset)
      prefix_ff <= hdf_pkg::HTTP_PREFIX_LEN || prefix_ff == hdf_pkg::PREFIX_MISMATCH)
      else $error("prefix progress out of range");

endmodule

### rtl/core/hdf_queue.sv
`timescale 1ns / 1ps
// Short queue of result entries between the front and back parts.
// Depends on hdf_pkg.
module hdf_queue #(
   parameter int DEPTH = hdf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hdf_pkg::res_entry_type wr_entry,
   input  logic                   pop,
   output hdf_pkg::res_entry_type rd_entry,
   output logic                   full,
   output logic                   empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hdf_pkg::res_entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign rd_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ptr_ff] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("pointers differ on an empty queue");

endmodule

### rtl/core/hdf_back.sv
`timescale 1ns / 1ps
// Back part of the deframer: splits each queued entry into one or two result
// words on the output queue interface. Depends on hdf_pkg.
module hdf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  hdf_pkg::res_entry_type head,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_body_byte,
   output logic                   rsp_success,
   output logic [15:0]            rsp_http_status,
   output logic                   rsp_last
);

   logic sent_ff, sent_in;
   logic show_data;
   logic taken;

   assign show_data = head.has_data && !sent_ff;
   assign taken     = rsp_pop && !q_empty;
   assign rsp_empty = q_empty;

   assign rsp_kind        = !show_data;
   assign rsp_body_byte   = show_data ? head.data : 8'd0;
   assign rsp_success     = show_data ? 1'b0 : head.success;
   assign rsp_http_status = show_data ? 16'd0 : head.status;
   assign rsp_last        = !show_data || !head.has_cmp;

   assign q_pop   = taken && rsp_last;
   assign sent_in = taken ? (show_data && head.has_cmp) : sent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= 1'b0;
      end else begin
         sent_ff <= sent_in;
      end
   end

   a_sent_needs_cmp: assert property (@(posedge clock) disable iff (reset)
      (sent_ff && !q_empty) |-> head.has_cmp)
      else $error("second word pending without a completion");
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !sent_ff)
      else $error("split state left set after entry retired");
   a_data_then_cmp: assert property (@(posedge clock) disable iff (reset)
      (taken && !rsp_last) |=> (!q_empty && rsp_kind))
      else $error("completion did not follow its data word");

endmodule

### rtl/core/http_response_deframer_core.sv
`timescale 1ns / 1ps
// HTTP response deframer top level. Depends on hdf_pkg, hdf_front, hdf_queue
// and hdf_back.
// A result word is stored in the registered queue before the rsp_ ports.
// Throughput: one input word per cycle while full is low; the front parser
// updates its state per word; output drains a word per cycle while pop is high.
// Reset is synchronous and clears the parser, the queue and head_request.
module http_response_deframer_core #(
   parameter int LINE_BUFFER = hdf_pkg::LINE_BUFFER_DEF,
   parameter int SIZE_DIGITS = hdf_pkg::SIZE_DIGITS_DEF,
   parameter int QUEUE_DEPTH = hdf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_success,
   output logic [15:0] rsp_http_status,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                   head_request_ff, head_request_in;
   logic                   accept;
   logic                   f_push;
   hdf_pkg::res_entry_type f_entry;
   hdf_pkg::res_entry_type q_head;
   logic                   q_empty;
   logic                   q_pop;
   logic                   reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == hdf_pkg::REG_HEAD_REQUEST);
   assign prdata  = reg_hit ? {31'd0, head_request_ff} : 32'd0;
   assign head_request_in = (psel && penable && pwrite && reg_hit) ?
                            pwdata[0] : head_request_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_request_ff <= 1'b0;
      end else begin
         head_request_ff <= head_request_in;
      end
   end

   assign accept = push && !full;

   hdf_front #(
      .LINE_BUFFER(LINE_BUFFER),
      .SIZE_DIGITS(SIZE_DIGITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_command),
      .data_byte   (req_data_byte),
      .head_request(head_request_ff),
      .push        (f_push),
      .entry       (f_entry)
   );

   hdf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (f_push),
      .wr_entry(f_entry),
      .pop     (q_pop),
      .rd_entry(q_head),
      .full    (full),
      .empty   (q_empty)
   );

   hdf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (empty),
      .rsp_pop        (pop),
      .rsp_kind       (rsp_kind),
      .rsp_body_byte  (rsp_body_byte),
      .rsp_success    (rsp_success),
      .rsp_http_status(rsp_http_status),
      .rsp_last       (rsp_last)
   );

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("results present right after reset");
   a_cmp_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind) |-> rsp_last)
      else $error("completion word not marked last");
   a_data_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_kind) |-> (!rsp_success && rsp_http_status == 16'd0))
      else $error("data word carries completion fields");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for http_response_deframer_core: drives HTTP response
// words through the queue-style ports and checks every result word against a
// built-in parser model. Depends on hdf_pkg and the RTL under rtl/core.
module testbench;

   typedef struct packed {
      logic        kind;
      logic [7:0]  body_byte;
      logic        success;
      logic [15:0] http_status;
      logic        last;
   } result_word_type;

   localparam logic [7:0] CH_NUL = 8'h00;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic [1:0]  req_command = hdf_pkg::CMD_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        pop = 1'b0;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic        full, empty, rsp_kind, rsp_success, rsp_last, pready;
   logic [7:0]  rsp_body_byte;
   logic [15:0] rsp_http_status;
   logic [31:0] prdata;

   http_response_deframer_core dut (.*);

   always #1 clock = ~clock;

   result_word_type expected_words[$];
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;
   int  sent = 0;

   // Parser model state.
   logic        head_req;
   logic [1:0]  stage;
   int unsigned line_count, prefix_progress, word_progress, size_digits;
   logic        awaiting_lf;
   logic [7:0]  line_flags;
   logic [15:0] status_code;
   logic [31:0] length_remaining, chunk_left;
   logic        length_known, chunked_mode;
   int unsigned chunk_phase;
   result_word_type step_words[$];

   localparam logic [1:0] STG_HEAD = 2'd0, STG_BODY = 2'd1, STG_DONE = 2'd2;
   localparam int CPH_SIZE = 0, CPH_SIZE_LF = 1, CPH_DATA = 2, CPH_DATA_CR = 3,
                  CPH_DATA_LF = 4, CPH_TRAILER = 5;
   localparam logic [7:0] FL_COLON = 8'h01, FL_SPACE = 8'h02, FL_CLBAD = 8'h04,
                          FL_TEBAD = 8'h08, FL_NEG = 8'h10, FL_ISCL = 8'h20,
                          FL_ISTE = 8'h40, FL_STAT = 8'h80;

   function automatic logic [7:0] lower_of(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic white(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      logic [7:0] l;
      l = lower_of(c);
      if (c >= "0" && c <= "9") return c - "0";
      if (l >= "a" && l <= "f") return l - "a" + 10;
      return -1;
   endfunction

   task automatic restart_response();
      stage = STG_HEAD; line_count = 0; awaiting_lf = 0; prefix_progress = 0;
      line_flags = 0; word_progress = 0; status_code = 0; length_remaining = 0;
      length_known = 0; chunked_mode = 0; chunk_phase = CPH_SIZE; chunk_left = 0;
      size_digits = 0;
   endtask

   task automatic emit(logic kind, logic [7:0] b, logic ok, logic [15:0] st);
      result_word_type w;
      w = '{kind: kind, body_byte: b, success: ok, http_status: st, last: 1'b0};
      step_words.push_back(w);
   endtask

   task automatic finish_response(logic ok, logic [15:0] st);
      emit(1'b1, 8'h00, ok, st);
      stage = STG_DONE;
   endtask

   function automatic logic [31:0] decimal_feed(logic [7:0] c, logic [31:0] acc, bit sat);
      logic [31:0] d;
      logic dig;
      d = c - "0";
      dig = c >= "0" && c <= "9";
      if (word_progress == 0) begin
         if (white(c)) return acc;
         word_progress = 1;
         if (c == "-") begin
            line_flags |= FL_NEG;
            return acc;
         end
         if (c == "+") return acc;
         if (!dig) begin
            word_progress = 2;
            return acc;
         end
      end else if (word_progress != 1 || !dig) begin
         word_progress = 2;
         return acc;
      end
      if (!sat) return (acc * 10 + d) & 32'hFFFF;
      if (acc > (32'hFFFFFFFF - d) / 10) return 32'hFFFFFFFF;
      return acc * 10 + d;
   endfunction

   task automatic header_byte(logic [7:0] b);
      string hp, cl, te, ck;
      int unsigned p;
      logic [7:0] c;
      hp = "HTTP/"; cl = "content-length"; te = "transfer-encoding"; ck = "chunked";
      if (awaiting_lf) begin
         awaiting_lf = 0;
         if (b != hdf_pkg::CH_LF) finish_response(1'b0, 16'd0);
         else if (line_count == 0) begin
            line_flags = 0; word_progress = 0; size_digits = 0;
            chunk_phase = CPH_SIZE; chunk_left = 0;
            if (head_req || status_code == hdf_pkg::STATUS_NO_CONTENT ||
                status_code == hdf_pkg::STATUS_NOT_MODIFIED)
               finish_response(1'b1, status_code);
            else if (!chunked_mode && length_known && length_remaining == 0)
               finish_response(1'b1, status_code);
            else stage = STG_BODY;
         end else begin
            if (prefix_progress == 5) begin
               if ((line_flags & (FL_STAT | FL_NEG)) == (FL_STAT | FL_NEG))
                  status_code = 16'd0 - status_code;
            end else if (line_flags & FL_ISCL) begin
               if ((line_flags & FL_NEG) && length_remaining != 0) begin
                  length_known = 0; length_remaining = 0;
               end else length_known = 1;
            end
            line_count = 0; prefix_progress = 0; line_flags = 0; word_progress = 0;
         end
         return;
      end
      if (b == hdf_pkg::CH_CR) begin
         awaiting_lf = 1;
         return;
      end
      if (line_count >= hdf_pkg::LINE_BUFFER_DEF - 1) return;
      p = line_count++;
      if (prefix_progress < 5)
         prefix_progress = (b == hp[prefix_progress]) ? prefix_progress + 1 : 7;
      if (line_flags & FL_STAT)
         status_code = 16'(decimal_feed(b, {16'd0, status_code}, 1'b0));
      else if (line_flags & FL_ISCL)
         length_remaining = decimal_feed(b, length_remaining, 1'b1);
      else if ((line_flags & FL_ISTE) && word_progress < 7) begin
         c = lower_of(b);
         word_progress = (c == ck[word_progress]) ? word_progress + 1 : (c == "c" ? 1 : 0);
         if (word_progress == 7) chunked_mode = 1;
      end
      if (!(line_flags & FL_SPACE) && b == hdf_pkg::CH_SPACE) begin
         line_flags |= FL_SPACE;
         if (prefix_progress == 5) begin
            line_flags |= FL_STAT; line_flags &= ~FL_NEG;
            status_code = 0; word_progress = 0;
         end
      end
      if (!(line_flags & FL_COLON)) begin
         if (b == hdf_pkg::CH_COLON) begin
            line_flags |= FL_COLON;
            if (prefix_progress != 5) begin
               if (!(line_flags & FL_CLBAD) && p == hdf_pkg::CL_NAME_LEN) begin
                  line_flags |= FL_ISCL; line_flags &= ~FL_NEG;
                  length_remaining = 0; word_progress = 0;
               end else if (!(line_flags & FL_TEBAD) && p == hdf_pkg::TE_NAME_LEN) begin
                  line_flags |= FL_ISTE; word_progress = 0;
               end
            end
         end else begin
            if (p >= hdf_pkg::CL_NAME_LEN || lower_of(b) != cl[p]) line_flags |= FL_CLBAD;
            if (p >= hdf_pkg::TE_NAME_LEN || lower_of(b) != te[p]) line_flags |= FL_TEBAD;
         end
      end
   endtask

   task automatic size_char(logic [7:0] c);
      int h;
      h = hex_digit(c);
      if (word_progress == 0) begin
         if (white(c)) return;
         if (c == "-" || c == "+") begin
            if (c == "-") line_flags |= FL_NEG;
            word_progress = 1;
            return;
         end
         word_progress = 1;
      end
      if (word_progress == 1) begin
         if (h < 0) word_progress = 3;
         else if (h == 0) begin
            chunk_left = 0; word_progress = 4;
         end else begin
            chunk_left = 32'(h); word_progress = 2;
         end
         return;
      end
      if (word_progress == 4) begin
         if (c == "x" || c == "X") begin
            word_progress = 2;
            return;
         end
         word_progress = 2;
      end
      if (word_progress == 2) begin
         if (h < 0) word_progress = 3;
         else chunk_left = (chunk_left << 4) | 32'(h);
      end
   endtask

   task automatic chunk_byte(logic [7:0] b);
      case (chunk_phase)
         CPH_SIZE: begin
            if (b == hdf_pkg::CH_CR) chunk_phase = CPH_SIZE_LF;
            else if (size_digits < hdf_pkg::SIZE_DIGITS_DEF) begin
               size_digits++;
               size_char(b);
            end
         end
         CPH_SIZE_LF: begin
            if (b == hdf_pkg::CH_LF) begin
               if (line_flags & FL_NEG) chunk_left = 32'd0 - chunk_left;
               size_digits = 0; word_progress = 0; line_flags = 0;
               chunk_phase = (chunk_left == 0) ? CPH_TRAILER : CPH_DATA;
            end
         end
         CPH_DATA: begin
            emit(1'b0, b, 1'b0, 16'd0);
            if (chunk_left > 0) chunk_left--;
            if (chunk_left == 0) chunk_phase = CPH_DATA_CR;
         end
         CPH_DATA_CR: if (b == hdf_pkg::CH_CR) chunk_phase = CPH_DATA_LF;
         CPH_DATA_LF: if (b == hdf_pkg::CH_LF) chunk_phase = CPH_SIZE;
         CPH_TRAILER: if (b == hdf_pkg::CH_LF) finish_response(1'b1, status_code);
         default: ;
      endcase
   endtask

   task automatic predict_word(logic [1:0] cmd, logic [7:0] b);
      step_words.delete();
      if (cmd == hdf_pkg::CMD_START) begin
         restart_response();
         return;
      end
      if (stage == STG_HEAD) begin
         if (cmd != hdf_pkg::CMD_BYTE) finish_response(1'b0, 16'd0);
         else header_byte(b);
      end else if (stage == STG_BODY) begin
         if (cmd == hdf_pkg::CMD_TIMEOUT) finish_response(1'b0, status_code);
         else if (cmd == hdf_pkg::CMD_CLOSE)
            finish_response((chunked_mode || length_known) ? 1'b0 : 1'b1, status_code);
         else if (chunked_mode) chunk_byte(b);
         else begin
            emit(1'b0, b, 1'b0, 16'd0);
            if (length_known) begin
               if (length_remaining > 0) length_remaining--;
               if (length_remaining == 0) finish_response(1'b1, status_code);
            end
         end
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   task automatic send_word(logic [1:0] cmd, logic [7:0] b);
      while (!calm && $urandom_range(99) < 26) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_command <= cmd;
      req_data_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_word(cmd, b);
      sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(hdf_pkg::CMD_BYTE, s[i]);
   endtask

   task automatic send_line(string s);
      send_text(s);
      send_word(hdf_pkg::CMD_BYTE, hdf_pkg::CH_CR);
      send_word(hdf_pkg::CMD_BYTE, hdf_pkg::CH_LF);
   endtask

   task automatic drain_results();
      push <= 1'b0;
      while (expected_words.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_head_request(logic v);
      drain_results();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 3'(hdf_pkg::REG_HEAD_REQUEST) * 3'd4; pwdata <= {31'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      head_req = v;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result checker: pop is randomised, a word is taken when pop and not empty.
   always @(posedge clock) begin
      result_word_type exp_w;
      if (!reset && pop && !empty) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word kind=%0d", rsp_kind);
            mismatches++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_kind !== exp_w.kind) begin
               $error("kind expected %0d actual %0d", exp_w.kind, rsp_kind); mismatches++;
            end
            if (rsp_body_byte !== exp_w.body_byte) begin
               $error("body_byte expected %0h actual %0h", exp_w.body_byte, rsp_body_byte);
               mismatches++;
            end
            if (rsp_success !== exp_w.success) begin
               $error("success expected %0d actual %0d", exp_w.success, rsp_success);
               mismatches++;
            end
            if (rsp_http_status !== exp_w.http_status) begin
               $error("http_status expected %0d actual %0d", exp_w.http_status,
                      rsp_http_status);
               mismatches++;
            end
            if (rsp_last !== exp_w.last) begin
               $error("last expected %0d actual %0d", exp_w.last, rsp_last); mismatches++;
            end
         end
      end
      pop <= reset ? 1'b0 : (calm || $urandom_range(99) >= 26);
   end

   task automatic test_directed();
      send_word(hdf_pkg::CMD_START, 8'h00);
      send_line("HTTP/1.1 200 OK");
      send_line("Content-Length: 3");
      send_line("");
      send_text("abc");
      send_word(hdf_pkg::CMD_BYTE, 8'hFF);
      send_word(hdf_pkg::CMD_CLOSE, 8'h00);
      send_word(hdf_pkg::CMD_START, 8'h00);
      send_line("HTTP/1.1 204 X");
      send_line("");
      send_word(hdf_pkg::CMD_START, 8'h00);
      send_word(hdf_pkg::CMD_BYTE, CH_NUL);
      send_word(hdf_pkg::CMD_BYTE, hdf_pkg::CH_CR);
      send_word(hdf_pkg::CMD_BYTE, 8'h41);
      send_word(hdf_pkg::CMD_START, 8'h00);
      send_word(hdf_pkg::CMD_TIMEOUT, 8'h00);
   endtask

   task automatic test_chunked();
      send_word(hdf_pkg::CMD_START, 8'h00);
      send_line("HTTP/1.1 -200 OK");
      send_line("TRANSFER-encoding: gzip, Chunked");
      send_line("");
      send_line(" 0x3");
      send_text("xyz");
      send_line("junk");
      send_line("-ffffffe");
      send_text("pq");
      send_line("");
      send_line("0");
      send_line("");
      send_word(hdf_pkg::CMD_START, 8'h00);
      send_line("HTTP/1.1 200");
      send_line("content-length: -5");
      send_line("");
      send_text("zz");
      send_word(hdf_pkg::CMD_CLOSE, 8'h00);
   endtask

   task automatic test_head_request();
      write_head_request(1'b1);
      send_word(hdf_pkg::CMD_START, 8'h00);
      send_line("HTTP/1.1 304");
      send_line("Content-Length: 99999999999");
      send_line("");
      send_word(hdf_pkg::CMD_TIMEOUT, 8'h00);
      write_head_request(1'b0);
   endtask

   task automatic random_response();
      int mode;
      string s;
      mode = $urandom_range(9);
      send_word(hdf_pkg::CMD_START, 8'h00);
      s = $sformatf("HTTP/1.%0d %0d OK", $urandom_range(1), $urandom_range(999));
      if (mode == 0) s = {s, "\r"};
      send_line(s);
      if (mode < 5) send_line($sformatf("content-length: %0d", $urandom_range(12)));
      else if (mode < 9) send_line("Transfer-Encoding: chunked");
      else send_line("X-Other: 1");
      send_line("");
      if (mode >= 5 && mode < 9) begin
         repeat ($urandom_range(3)) begin
            int k;
            k = $urandom_range(1, 6);
            send_line($sformatf("%0x", k));
            repeat (k) send_word(hdf_pkg::CMD_BYTE, 8'($urandom));
            send_line("");
         end
         send_line("0");
         send_line("");
      end else begin
         repeat ($urandom_range(14)) send_word(hdf_pkg::CMD_BYTE, 8'($urandom));
      end
      if ($urandom_range(3) == 0)
         send_word(($urandom_range(1) != 0) ? hdf_pkg::CMD_CLOSE : hdf_pkg::CMD_TIMEOUT,
                   8'($urandom));
   endtask

   task automatic test_random();
      int target;
      target = sent + 850;
      while (sent < target) begin
         calm = (sent > target - 250 && sent < target - 100);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 10))
               send_word(2'($urandom), 8'($urandom));
         end else random_response();
         if ($urandom_range(40) == 0) write_head_request(1'($urandom));
      end
      calm = 1'b0;
   endtask

   initial begin
      head_req = 1'b0;
      restart_response();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_chunked();
      test_head_request();
      write_head_request(1'b0);
      test_random();
      write_head_request(1'b1);
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
